[sv/rhsc_pkg.sv]
// Package for the RGB/HSV skin classifier: widths, register indexes, reset values
// and the sideband record that travels beside the hue divider.
// No dependencies.
package rhsc_pkg;

    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int DIV_STEPS_DEF     = 4;

    localparam int COMP_W      = 8;
    localparam int WORD_W      = 24;
    localparam int SUM_W       = 10;
    localparam int HUE_FIXED_W = 15;
    localparam int T_W         = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_REJECT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_REJECT_HIGH = 3'd4;

    localparam logic [COMP_W-1:0]      VALUE_MIN_RST       = 8'd41;
    localparam logic [COMP_W-1:0]      CHROMA_MIN_RST      = 8'd8;
    localparam logic [COMP_W-1:0]      CHROMA_MAX_RST      = 8'd140;
    localparam logic [HUE_FIXED_W-1:0] HUE_REJECT_LOW_RST  = 15'd4480;
    localparam logic [HUE_FIXED_W-1:0] HUE_REJECT_HIGH_RST = 15'd18880;

    localparam logic [WORD_W-1:0] STEP_ONE = 24'h010101;
    localparam logic [WORD_W-1:0] ALL_ONES = 24'hFFFFFF;

    typedef struct packed {
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] ch;
        logic [SUM_W-1:0]  sum;
        logic              undef;
        logic [SUM_W-1:0]  darkest;
        logic [SUM_W-1:0]  brightest;
        logic [WORD_W-1:0] darker;
        logic [WORD_W-1:0] lighter;
        logic [WORD_W-1:0] inverted;
    } rhsc_side_t;

endpackage

[sv/rhsc_div.sv]
// Pipelined restoring divider for the hue: dividend over chroma, a few quotient bits
// per register stage, with the pixel's sideband record carried alongside.
// Depends on rhsc_pkg.
module rhsc_div import rhsc_pkg::*; #(
    parameter int QUOT_W          = 16,
    parameter int STEPS_PER_STAGE = DIV_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [QUOT_W+COMP_W-1:0] in_dividend,
    input  rhsc_side_t               in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [QUOT_W-1:0]        out_quotient,
    output rhsc_side_t               out_side
);

    localparam int STAGES = QUOT_W / STEPS_PER_STAGE;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;
    logic [COMP_W-1:0] rem_reg  [STAGES];
    logic [QUOT_W-1:0] num_reg  [STAGES];
    rhsc_side_t        side_reg [STAGES];

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        en[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
        logic              src_v;
        logic [COMP_W-1:0] src_rem;
        logic [QUOT_W-1:0] src_num;
        rhsc_side_t        src_side;
        logic [COMP_W-1:0] rem_next;
        logic [QUOT_W-1:0] num_next;

        if (gi == 0) begin : g_first
            // The quotient fits in QUOT_W bits, so the top bits are already below chroma.
            assign src_v    = in_valid;
            assign src_rem  = in_dividend[QUOT_W+COMP_W-1:QUOT_W];
            assign src_num  = in_dividend[QUOT_W-1:0];
            assign src_side = in_side;
        end else begin : g_next
            assign src_v    = v_reg[gi-1];
            assign src_rem  = rem_reg[gi-1];
            assign src_num  = num_reg[gi-1];
            assign src_side = side_reg[gi-1];
        end

        // Dividend bits shift out at the top while quotient bits shift in at the bottom.
        always_comb begin
            logic [COMP_W:0] trial;
            rem_next = src_rem;
            num_next = src_num;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                trial    = {rem_next, num_next[QUOT_W-1]};
                num_next = {num_next[QUOT_W-2:0], 1'b0};
                if (trial >= {1'b0, src_side.ch}) begin
                    trial       = trial - {1'b0, src_side.ch};
                    num_next[0] = 1'b1;
                end
                rem_next = trial[COMP_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[gi] <= 1'b0;
            end else if (en[gi]) begin
                v_reg[gi] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[gi]) begin
                rem_reg[gi]  <= rem_next;
                num_reg[gi]  <= num_next;
                side_reg[gi] <= src_side;
            end
        end
    end

    assign in_ready     = en[0];
    assign out_valid    = v_reg[STAGES-1];
    assign out_quotient = num_reg[STAGES-1];
    assign out_side     = side_reg[STAGES-1];

endmodule

[sv/rgb_hsv_skin_classifier.sv]
// Throughput: one pixel per cycle unless m_ready stalls the output; three front stages,
// the hue divider's stages (four quotient bits each) and an output register, each
// holding its own valid bit. Reset (aresetn, synchronous, active low) empties the
// pipeline and loads the thresholds with 41, 8, 140, 4480 and 18880.
module rgb_hsv_skin_classifier import rhsc_pkg::*; #(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [WORD_W-1:0]      s_colour_word,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [HUE_FIXED_W-1:0] m_hue_fixed,
    output logic                   m_hue_undefined,
    output logic [COMP_W-1:0]      m_max_component,
    output logic [COMP_W-1:0]      m_chroma,
    output logic [SUM_W-1:0]       m_component_sum,
    output logic                   m_is_skin,
    output logic [SUM_W-1:0]       m_darkest_sum,
    output logic [SUM_W-1:0]       m_brightest_sum,
    output logic [WORD_W-1:0]      m_darker_word,
    output logic [WORD_W-1:0]      m_lighter_word,
    output logic [WORD_W-1:0]      m_inverted_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
    localparam int HUE_MUL  = 60 << HUE_FRAC_BITS;
    localparam int QW       = $clog2(HUE_FULL);
    localparam int QUOT_W   = ((QW + DIV_STEPS_DEF - 1) / DIV_STEPS_DEF) * DIV_STEPS_DEF;
    localparam int NUM_W    = QUOT_W + COMP_W;
    localparam int HUE_W    = (QUOT_W > HUE_FIXED_W) ? QUOT_W : HUE_FIXED_W;

    // Threshold registers.
    logic [COMP_W-1:0]      value_min_reg;
    logic [COMP_W-1:0]      chroma_min_reg;
    logic [COMP_W-1:0]      chroma_max_reg;
    logic [HUE_FIXED_W-1:0] hue_low_reg;
    logic [HUE_FIXED_W-1:0] hue_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_min_reg  <= VALUE_MIN_RST;
            chroma_min_reg <= CHROMA_MIN_RST;
            chroma_max_reg <= CHROMA_MAX_RST;
            hue_low_reg    <= HUE_REJECT_LOW_RST;
            hue_high_reg   <= HUE_REJECT_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VALUE_MIN:       value_min_reg  <= cfg_data[COMP_W-1:0];
                CFG_CHROMA_MIN:      chroma_min_reg <= cfg_data[COMP_W-1:0];
                CFG_CHROMA_MAX:      chroma_max_reg <= cfg_data[COMP_W-1:0];
                CFG_HUE_REJECT_LOW:  hue_low_reg    <= cfg_data;
                CFG_HUE_REJECT_HIGH: hue_high_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables, from the output back to the input.
    logic a_en, b_en, c_en, d_en;
    logic div_in_ready;
    logic a_v_reg, b_v_reg, c_v_reg, m_valid_reg;

    assign d_en    = !m_valid_reg || m_ready;
    assign c_en    = !c_v_reg || div_in_ready;
    assign b_en    = !b_v_reg || c_en;
    assign a_en    = !a_v_reg || b_en;
    assign s_ready = a_en;

    // Stage A: split the word and find the largest and smallest component.
    logic [COMP_W-1:0] in_r, in_g, in_b, in_mx_rg, in_mn_rg, a_mx_next, a_mn_next;
    logic [WORD_W-1:0] a_word_reg;
    logic [COMP_W-1:0] a_mx_reg, a_mn_reg;

    always_comb begin
        in_r      = s_colour_word[7:0];
        in_g      = s_colour_word[15:8];
        in_b      = s_colour_word[23:16];
        in_mx_rg  = (in_r > in_g) ? in_r : in_g;
        in_mn_rg  = (in_r < in_g) ? in_r : in_g;
        a_mx_next = (in_mx_rg > in_b) ? in_mx_rg : in_b;
        a_mn_next = (in_mn_rg < in_b) ? in_mn_rg : in_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (a_en) begin
            a_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_word_reg <= s_colour_word;
            a_mx_reg   <= a_mx_next;
            a_mn_reg   <= a_mn_next;
        end
    end

    // Stage B: chroma, sums, neighbour colours and the sector offset t in 0..6*chroma-1.
    logic [COMP_W-1:0] a_r, a_g, a_b, a_ch;
    logic [11:0]       t_raw, t_wrap;
    logic [T_W-1:0]    b_t_next;
    rhsc_side_t        b_side_next;
    logic [T_W-1:0]    b_t_reg;
    rhsc_side_t        b_side_reg;

    always_comb begin
        a_r  = a_word_reg[7:0];
        a_g  = a_word_reg[15:8];
        a_b  = a_word_reg[23:16];
        a_ch = a_mx_reg - a_mn_reg;
        if (a_r == a_mx_reg) begin
            t_raw = {4'b0, a_g} - {4'b0, a_b};
        end else if (a_g == a_mx_reg) begin
            t_raw = {3'b0, a_ch, 1'b0} + {4'b0, a_b} - {4'b0, a_r};
        end else begin
            t_raw = {2'b0, a_ch, 2'b0} + {4'b0, a_r} - {4'b0, a_g};
        end
        // Only the red sector can go negative; wrap it by a full turn.
        t_wrap = t_raw;
        if (t_raw[11]) begin
            t_wrap = t_raw + {2'b0, a_ch, 2'b0} + {3'b0, a_ch, 1'b0};
        end
        b_t_next = t_wrap[T_W-1:0];

        b_side_next.mx        = a_mx_reg;
        b_side_next.ch        = a_ch;
        b_side_next.sum       = {2'b0, a_r} + {2'b0, a_g} + {2'b0, a_b};
        b_side_next.undef     = (a_ch == '0);
        b_side_next.darkest   = b_side_next.sum - {1'b0, a_mn_reg, 1'b0} - {2'b0, a_mn_reg};
        b_side_next.brightest = b_side_next.sum + {1'b0, ~a_mx_reg, 1'b0} + {2'b0, ~a_mx_reg};
        b_side_next.darker    = (a_mn_reg == '0) ? a_word_reg : a_word_reg - STEP_ONE;
        b_side_next.lighter   = (a_mx_reg == '1) ? a_word_reg : a_word_reg + STEP_ONE;
        b_side_next.inverted  = a_word_reg ^ ALL_ONES;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (b_en) begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_t_reg    <= b_t_next;
            b_side_reg <= b_side_next;
        end
    end

    // Stage C: scale t by 60 degrees in hue fraction units.
    logic [NUM_W-1:0] c_num_reg;
    rhsc_side_t       c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (c_en) begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            c_num_reg  <= NUM_W'(HUE_MUL) * NUM_W'(b_t_reg);
            c_side_reg <= b_side_reg;
        end
    end

    // Hue divider.
    logic              div_out_valid;
    logic [QUOT_W-1:0] div_quot;
    rhsc_side_t        div_side;

    rhsc_div #(
        .QUOT_W          (QUOT_W),
        .STEPS_PER_STAGE (DIV_STEPS_DEF)
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (c_v_reg),
        .in_ready     (div_in_ready),
        .in_dividend  (c_num_reg),
        .in_side      (c_side_reg),
        .out_valid    (div_out_valid),
        .out_ready    (d_en),
        .out_quotient (div_quot),
        .out_side     (div_side)
    );

    // Stage D: skin tests and the output register.
    logic [HUE_W-1:0] hue_full;
    logic             hue_ok, val_ok, chr_ok;

    logic [HUE_FIXED_W-1:0] m_hue_fixed_reg;
    logic                   m_is_skin_reg;
    rhsc_side_t             m_side_reg;

    always_comb begin
        hue_full = div_side.undef ? '0 : HUE_W'(div_quot);
        hue_ok   = div_side.undef
                   || !(hue_full > HUE_W'(hue_low_reg) && hue_full < HUE_W'(hue_high_reg));
        val_ok   = div_side.mx >= value_min_reg;
        chr_ok   = (div_side.ch >= chroma_min_reg) && (div_side.ch <= chroma_max_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_en) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_en) begin
            m_hue_fixed_reg <= hue_full[HUE_FIXED_W-1:0];
            m_is_skin_reg   <= hue_ok && val_ok && chr_ok;
            m_side_reg      <= div_side;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hue_fixed     = m_hue_fixed_reg;
    assign m_hue_undefined = m_side_reg.undef;
    assign m_max_component = m_side_reg.mx;
    assign m_chroma        = m_side_reg.ch;
    assign m_component_sum = m_side_reg.sum;
    assign m_is_skin       = m_is_skin_reg;
    assign m_darkest_sum   = m_side_reg.darkest;
    assign m_brightest_sum = m_side_reg.brightest;
    assign m_darker_word   = m_side_reg.darker;
    assign m_lighter_word  = m_side_reg.lighter;
    assign m_inverted_word = m_side_reg.inverted;

    // Checks on the result record.
    a_undef_matches_chroma: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue_undefined == (m_chroma == '0)))
        else $error("hue_undefined disagrees with chroma");

    a_undef_hue_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hue_undefined |-> (m_hue_fixed == '0))
        else $error("undefined hue is not zero");

    a_chroma_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_chroma <= m_max_component))
        else $error("chroma exceeds the largest component");

    // A zero chroma divides by zero in the divider; that quotient is never used.
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out_valid && !div_side.undef |-> (32'(div_quot) < HUE_FULL))
        else $error("hue quotient outside one turn");

endmodule
